[rtl/core/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes of the bitmap page allocator: request and response
// transactions, status and command codes, register indexes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_GROUPS = 4'd1;

    localparam logic [7:0] GROUP_FULL = 8'hFF;

    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
    } t_rsp;

    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic scan_step;
        logic free_read;
        logic free_check;
        logic res_full;
        logic res_bad;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic grp_zero;
        logic scan_hit;
        logic scan_end;
        logic free_oor;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// bpa_datapath
// Page map memory, configuration registers, group scan counter, free
// address decode and the pending and output result registers.
// ----------------------------------------------------------------------------
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int GROUPS     = 128,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  t_req                 i_req,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_rsp_ready,
    output logic                 o_rsp_valid,
    output t_rsp                 o_rsp
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW = $clog2(GROUPS + 1);
    localparam int LW = (CW > 8) ? CW : 8;
    localparam logic [LW-1:0] GRP_L  = LW'(GROUPS);
    localparam logic [GW-1:0] GRP_LAST = GW'(GROUPS - 1);

    logic [7:0]    r_mem [GROUPS];
    logic [7:0]    r_rd_data;
    logic [31:0]   r_base;
    logic [7:0]    r_ngrp;
    logic [31:0]   r_offset;
    logic [LW-1:0] r_grp;
    logic [GW-1:0] r_chk_grp;
    logic          r_chk_valid;
    logic [GW-1:0] r_clr;
    t_rsp          r_res;
    t_rsp          r_out;
    logic          r_out_valid;

    logic [LW-1:0] n_use;
    logic [LW-1:0] ngrp_l;
    logic          issue;
    logic          mem_re;
    logic [GW-1:0] mem_ra;
    logic          mem_we;
    logic [GW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [GW-1:0] free_grp;
    logic [2:0]    free_bit;
    logic          free_set;
    logic          hit;
    logic [2:0]    hit_bit;
    logic [31:0]   hit_addr;

    assign ngrp_l   = LW'(r_ngrp);
    assign n_use    = (ngrp_l > GRP_L) ? GRP_L : ngrp_l;
    assign issue    = i_cmd.scan_step && (r_grp < n_use);
    assign free_grp = r_offset[PAGE_SHIFT+3 +: GW];
    assign free_bit = r_offset[PAGE_SHIFT +: 3];
    assign free_set = r_rd_data[free_bit];
    assign hit      = r_chk_valid && (r_rd_data != GROUP_FULL);
    assign hit_addr = r_base + (32'({r_chk_grp, hit_bit}) << PAGE_SHIFT);

    always_comb begin
        hit_bit = 3'd7;
        for (int b = 6; b >= 0; b--) begin
            if (!r_rd_data[b]) begin
                hit_bit = 3'(b);
            end
        end
    end

    always_comb begin
        mem_re = issue || i_cmd.free_read;
        mem_ra = i_cmd.free_read ? free_grp : r_grp[GW-1:0];
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 8'h00;
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.scan_step && hit) begin
            mem_we = 1'b1;
            mem_wa = r_chk_grp;
            mem_wd = r_rd_data | (8'h01 << hit_bit);
        end else if (i_cmd.free_check && free_set) begin
            mem_we = 1'b1;
            mem_wa = free_grp;
            mem_wd = r_rd_data & ~(8'h01 << free_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_ngrp      <= 8'd128;
            r_clr       <= '0;
            r_chk_valid <= 1'b0;
            r_grp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_REGION_BASE:   r_base <= i_cfg_data;
                    REG_REGION_GROUPS: r_ngrp <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + GW'(1);
            end
            if (i_cmd.load_req) begin
                r_grp       <= '0;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_valid <= issue;
                if (issue) begin
                    r_grp <= r_grp + LW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_offset <= i_req.address - r_base;
        end
        if (i_cmd.scan_step) begin
            r_chk_grp <= r_grp[GW-1:0];
        end
        if (i_cmd.scan_step && hit) begin
            r_res <= '{status: ST_OK, alloc_addr: hit_addr};
        end else if (i_cmd.res_full) begin
            r_res <= '{status: ST_FULL, alloc_addr: 32'd0};
        end else if (i_cmd.res_bad) begin
            r_res <= '{status: ST_BAD_FREE, alloc_addr: 32'd0};
        end else if (i_cmd.free_check) begin
            r_res <= '{status: (free_set ? ST_OK : ST_BAD_FREE), alloc_addr: 32'd0};
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_sts.clr_done = (r_clr == GRP_LAST);
        o_sts.grp_zero = (n_use == '0);
        o_sts.scan_hit = hit;
        o_sts.scan_end = r_chk_valid && !hit && (LW'(r_chk_grp) == n_use - LW'(1));
        o_sts.free_oor = (32'(r_offset[31:PAGE_SHIFT+3]) >= 32'(n_use));
        o_sts.out_free = !r_out_valid || i_rsp_ready;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

[rtl/core/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller state machine: clear pass after reset, request intake, group
// scan for allocate, read-check-write for free, and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_req_cmd,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_POST
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_req_cmd == CMD_FREE) begin
                        n_state = S_FREE_RD;
                    end else if (i_sts.grp_zero) begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_POST;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_POST;
                end else if (i_sts.scan_end) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_POST;
                end
            end
            S_FREE_RD: begin
                if (i_sts.free_oor) begin
                    o_cmd.res_bad = 1'b1;
                    n_state       = S_POST;
                end else begin
                    o_cmd.free_read = 1'b1;
                    n_state         = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                o_cmd.free_check = 1'b1;
                n_state          = S_POST;
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page slot allocator over a bitmap of eight-page groups.
//
// Request channel (i_req_*): cmd selects allocate or free; address names the
// page to free. Response channel (o_rsp_*): one transaction per request with
// status and the allocated page address (zero unless an allocate succeeds).
// Configuration channel (i_cfg_*): index 0 writes region_base, index 1 writes
// region_groups; always ready, write only while the block is idle.
// Allocate: one map group is read per cycle until a group with a free page
// is found or all groups in use prove full; when no group is in use the
// result is full without any scan.
// Free: read, check and write back one group; an address outside the window
// is answered without a map read.
// One request is in work at a time; the next is accepted once the previous
// result has moved to the output register, even if that register is still
// waiting for i_rsp_ready.
// Reset: a clearing pass over all groups zeroes the page map; requests are
// held off until it ends. A stalled receiver holds the response and, once the
// following result is done, holds the request channel too.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int GROUPS     = 128,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output t_rsp                 o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_cmd   (i_req.cmd),
        .o_req_ready (o_req_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bpa_datapath #(
        .GROUPS     (GROUPS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_FULL ||
                         o_rsp.status == ST_BAD_FREE))
        else $error("response status code out of range");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |-> (o_rsp.alloc_addr == 32'd0))
        else $error("failed transaction carries a nonzero page address");

    a_no_req_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("request accepted during map clearing");
`endif

endmodule

[dv/bitmap_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Self-checking bench for the first-fit page allocator. A scoreboard model
// mirrors the page map and window registers and predicts every response.
// Directed checks cover the default window, an empty window, a filled group,
// a window that wraps past the top of the address space, an unaligned base,
// shrinking and regrowing the window and an unmapped register index. Random
// traffic then mixes allocates, frees of live pages and stray frees over many
// random windows. In most phases the request and response sides idle at random.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    localparam int NUM_GROUPS  = 128;
    localparam int PG_SHIFT    = 12;
    localparam int PAGE_BYTES  = 1 << PG_SHIFT;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 req_valid = 1'b0;
    t_req                 req       = '0;
    logic                 rsp_ready = 1'b0;
    logic                 cfg_ready;
    logic                 req_ready;
    logic                 rsp_valid;
    t_rsp                 rsp;

    logic [7:0]  page_map [NUM_GROUPS];
    logic [31:0] win_base;
    logic [7:0]  win_groups;
    t_rsp        pending_outcomes [$];
    int          err_count     = 0;
    int          send_idle_pct = 0;
    int          rsp_idle_pct  = 0;
    bit          hold_toggle   = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    bitmap_page_allocator #(
        .GROUPS     (NUM_GROUPS),
        .PAGE_SHIFT (PG_SHIFT)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int groups_in_use();
        return (win_groups > NUM_GROUPS) ? NUM_GROUPS : int'(win_groups);
    endfunction

    function automatic t_rsp apply_request(input t_req item);
        t_rsp        r;
        int          n;
        bit          hit;
        logic [31:0] offset;
        logic [31:0] page;
        logic [31:0] grp;
        logic [2:0]  slot;
        r.status     = ST_FULL;
        r.alloc_addr = '0;
        n   = groups_in_use();
        hit = 1'b0;
        if (item.cmd == CMD_ALLOC) begin
            for (int g = 0; g < n && !hit; g++) begin
                if (page_map[g] != GROUP_FULL) begin
                    for (int b = 7; b >= 0; b--) begin
                        if (!page_map[g][b]) slot = b[2:0];
                    end
                    page_map[g][slot] = 1'b1;
                    page               = g * 8 + slot;
                    r.status           = ST_OK;
                    r.alloc_addr       = win_base + (page << PG_SHIFT);
                    hit                = 1'b1;
                end
            end
        end else begin
            offset   = item.address - win_base;
            page     = offset >> PG_SHIFT;
            grp      = page >> 3;
            slot     = page[2:0];
            r.status = ST_BAD_FREE;
            if (grp < n) begin
                if (page_map[grp][slot]) begin
                    page_map[grp][slot] = 1'b0;
                    r.status            = ST_OK;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] live_page_address();
        int          n;
        int          g;
        int          b;
        logic [31:0] page;
        n = groups_in_use();
        if (n == 0) return $urandom;
        for (int t = 0; t < 16; t++) begin
            g = $urandom_range(n - 1);
            b = $urandom_range(7);
            if (page_map[g][b]) break;
        end
        page = g * 8 + b;
        return win_base + (page << PG_SHIFT)
             + (($urandom_range(3) == 0) ? $urandom_range(PAGE_BYTES - 1) : 0);
    endfunction

    task automatic send_request(input logic cmd, input logic [31:0] addr);
        t_req item;
        item.cmd     = cmd;
        item.address = addr;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        pending_outcomes.push_back(apply_request(item));
    endtask

    task automatic wait_all_outcomes();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wait_all_outcomes();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_REGION_BASE:   win_base   = data;
            REG_REGION_GROUPS: win_groups = data[7:0];
            default: ;
        endcase
    endtask

    task automatic test_default_window();
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 32'h0000_1FFF);
        send_request(CMD_FREE, 32'h0000_1000);
        send_request(CMD_FREE, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_groups();
        write_reg(REG_REGION_GROUPS, 32'h0000_0000);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h0000_0000);
    endtask

    task automatic test_single_group();
        write_reg(REG_REGION_BASE, 32'h8000_0000);
        write_reg(REG_REGION_GROUPS, 32'h0000_0001);
        repeat (9) send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h8000_3ABC);
        send_request(CMD_ALLOC, 32'h0000_0000);
    endtask

    task automatic test_wrapped_window();
        logic [31:0] addr;
        write_reg(REG_REGION_BASE, 32'hFFFF_F000);
        write_reg(REG_REGION_GROUPS, 32'h0000_0002);
        send_request(CMD_ALLOC, $urandom);
        addr = pending_outcomes[$].alloc_addr;
        send_request(CMD_FREE, addr);
        send_request(CMD_FREE, 32'hFFFF_EFFF);
    endtask

    task automatic test_unaligned_base();
        logic [31:0] addr;
        write_reg(REG_REGION_BASE, 32'h0000_0123);
        write_reg(REG_REGION_GROUPS, 32'h0000_00FF);
        send_request(CMD_ALLOC, $urandom);
        addr = pending_outcomes[$].alloc_addr;
        send_request(CMD_FREE, addr + 32'h0000_0ABC);
    endtask

    task automatic test_shrink_and_grow();
        logic [31:0] addr;
        write_reg(REG_REGION_BASE, 32'h0000_0000);
        write_reg(REG_REGION_GROUPS, 32'h0000_0002);
        send_request(CMD_ALLOC, $urandom);
        addr = pending_outcomes[$].alloc_addr;
        write_reg(REG_REGION_GROUPS, 32'hFFFF_FF01);
        send_request(CMD_FREE, addr);
        write_reg(REG_UNMAPPED, $urandom);
        send_request(CMD_FREE, addr);
        write_reg(REG_REGION_GROUPS, 32'h0000_0002);
        send_request(CMD_FREE, addr);
    endtask

    task automatic test_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        write_reg(REG_REGION_GROUPS, 32'h0000_0004);
        hold_toggle <= ~hold_toggle;
        repeat (10) send_request(CMD_ALLOC, $urandom);
        send_idle_pct = saved_pct;
        wait_all_outcomes();
    endtask

    task automatic random_window();
        logic [31:0] base;
        logic [7:0]  grp;
        int          pick;
        pick = $urandom_range(7);
        if (pick == 0)      base = $urandom;
        else if (pick == 1) base = 32'hFFFF_F000 - ($urandom_range(16) << PG_SHIFT);
        else                base = $urandom & 32'hFFFF_F000;
        case ($urandom_range(15))
            0:       grp = 8'd0;
            1:       grp = 8'(NUM_GROUPS);
            2:       grp = 8'hFF;
            3:       grp = 8'($urandom_range(255));
            default: grp = 8'($urandom_range(6, 1));
        endcase
        write_reg(REG_REGION_BASE, base);
        write_reg(REG_REGION_GROUPS, ($urandom & 32'hFFFF_FF00) | 32'(grp));
    endtask

    task automatic run_traffic(input int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 55)
                send_request(CMD_ALLOC, $urandom);
            else if (sel < 85)
                send_request(CMD_FREE, live_page_address());
            else if (sel < 93)
                send_request(CMD_FREE,
                             win_base + ($urandom_range(NUM_GROUPS * 8 + 15) << PG_SHIFT));
            else
                send_request(CMD_FREE, $urandom);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int rsp_pct, input int items);
        int sent;
        int burst;
        send_idle_pct = send_pct;
        rsp_idle_pct <= rsp_pct;
        sent = 0;
        while (sent < items) begin
            random_window();
            burst = $urandom_range(60, 20);
            run_traffic(burst);
            sent += burst;
        end
    endtask

    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected response status %0d address %h",
                         $time, rsp.status, rsp.alloc_addr);
                err_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp.status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    err_count++;
                end
                if (rsp.alloc_addr !== want.alloc_addr) begin
                    $display("%0t: alloc_addr mismatch expected %h actual %h",
                             $time, want.alloc_addr, rsp.alloc_addr);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (page_map[g]) page_map[g] = '0;
        win_base   = '0;
        win_groups = 8'(NUM_GROUPS);
        send_idle_pct = 8;
        rsp_idle_pct <= 86;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_default_window();
        test_zero_groups();
        test_single_group();
        test_wrapped_window();
        test_unaligned_base();
        test_shrink_and_grow();
        test_backpressure();
        test_random_traffic(8, 86, 300);
        test_random_traffic(86, 8, 300);
        test_random_traffic(0, 0, 300);

        wait_all_outcomes();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
